[sv/nml_pkg.sv]
// Shared types and constants for the nibble-mode parallel link.
package nml_pkg;

    typedef enum logic [1:0] {
        PHASE_IDLE    = 2'd0,
        PHASE_RX_LOW  = 2'd1,
        PHASE_TX_HIGH = 2'd2,
        PHASE_TX_LOW  = 2'd3
    } phase_t;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_TX_REQ = 1'b1
    } op_t;

    localparam int          STATUS_W        = 5;
    localparam int          TICK_W          = 16;
    localparam logic [15:0] TIMEOUT_RESET   = 16'd100;
    localparam logic [4:0]  BUSY_INVERT     = 5'h10;
    localparam logic [7:0]  FLAG_DRIVE      = 8'h10;
    localparam int          S_TDATA_W       = 16;
    localparam int          M_TDATA_W       = 24;

    typedef struct packed {
        logic [7:0] data_lines;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       tx_done;
        logic       tx_timed_out;
        logic       request_refused;
        phase_t     link_phase;
    } result_t;

endpackage

[sv/nibble_mode_parallel_link_core.sv]
// Top level of the nibble-mode parallel link: input register, handshake logic, result register.
//
//  channel  dir  fields (low bit up)
//  s_axis   in   tuser: operation; tdata: status_lines[4:0], tx_byte[12:5]
//  m_axis   out  tdata: data_lines, rx_valid, rx_byte, tx_done, tx_timed_out,
//                       request_refused, link_phase
//  cfg      in   cfg_wr_en / cfg_wr_data: timeout_ticks
//
// One item per clock while the output is not stalled: an item waits in the input
// register, then its result lands in the output register.
// Link state updates when an item moves from the input to the output register.
// A stalled output holds its result; the input register still refills as soon
// as its item moves on. Reset brings the link to idle with timeout 100.
module nibble_mode_parallel_link_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [nml_pkg::TICK_W-1:0]   cfg_wr_data,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [nml_pkg::S_TDATA_W-1:0] s_axis_tdata,  // status_lines[4:0], tx_byte[12:5]
    input  logic                         s_axis_tuser,  // operation
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [nml_pkg::M_TDATA_W-1:0] m_axis_tdata   // data_lines[7:0], rx_valid[8],
                                                         // rx_byte[16:9], tx_done[17],
                                                         // tx_timed_out[18],
                                                         // request_refused[19],
                                                         // link_phase[21:20]
);
    import nml_pkg::*;

    // input register
    logic                in_valid_reg;
    op_t                 in_op_reg;
    logic [STATUS_W-1:0] in_status_reg;
    logic [7:0]          in_txb_reg;

    // output register
    logic                out_valid_reg;
    result_t             out_reg;

    // link state
    logic [TICK_W-1:0]   timeout_reg;
    logic [STATUS_W-1:0] stable_reg, stable_next;
    logic                known_reg, known_next;
    logic [STATUS_W-1:0] prev_reg, prev_next;
    phase_t              phase_reg, phase_next;
    logic [3:0]          held_reg, held_next;
    logic [TICK_W-1:0]   elapsed_reg, elapsed_next;
    logic                tmo_seen_reg, tmo_seen_next;
    logic [7:0]          drive_reg, drive_next;
    result_t             res_next;

    logic advance;
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_op_reg     <= op_t'(s_axis_tuser);
            in_status_reg <= s_axis_tdata[STATUS_W-1:0];
            in_txb_reg    <= s_axis_tdata[STATUS_W+7:STATUS_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_wr_en)
        begin
            timeout_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg   <= '0;
            known_reg    <= 1'b0;
            prev_reg     <= '0;
            phase_reg    <= PHASE_IDLE;
            held_reg     <= '0;
            elapsed_reg  <= '0;
            tmo_seen_reg <= 1'b0;
            drive_reg    <= '0;
        end
        else if (advance)
        begin
            stable_reg   <= stable_next;
            known_reg    <= known_next;
            prev_reg     <= prev_next;
            phase_reg    <= phase_next;
            held_reg     <= held_next;
            elapsed_reg  <= elapsed_next;
            tmo_seen_reg <= tmo_seen_next;
            drive_reg    <= drive_next;
        end
    end

    logic [STATUS_W-1:0] pv;
    logic                flag_hi, flag_lo, wait_out;

    always_comb
    begin
        stable_next   = stable_reg;
        known_next    = known_reg;
        prev_next     = prev_reg;
        phase_next    = phase_reg;
        held_next     = held_reg;
        elapsed_next  = elapsed_reg;
        tmo_seen_next = tmo_seen_reg;
        drive_next    = drive_reg;
        res_next      = '0;

        // debounce: a value counts once two samples in a row agree
        if (in_status_reg == prev_reg)
        begin
            stable_next = in_status_reg;
            known_next  = 1'b1;
        end
        pv       = stable_next ^ BUSY_INVERT;
        flag_hi  = known_next && pv[4];
        flag_lo  = known_next && !pv[4];
        wait_out = elapsed_reg >= timeout_reg;

        if (in_op_reg == OP_TX_REQ)
        begin
            // no sampling, no tick
            stable_next = stable_reg;
            known_next  = known_reg;
            if (phase_reg == PHASE_IDLE)
            begin
                drive_next    = {4'h1, in_txb_reg[3:0]};
                held_next     = in_txb_reg[7:4];
                elapsed_next  = '0;
                tmo_seen_next = 1'b0;
                phase_next    = PHASE_TX_HIGH;
            end
            else
            begin
                res_next.request_refused = 1'b1;
            end
        end
        else
        begin
            prev_next = in_status_reg;
            unique case (phase_reg)
                PHASE_IDLE:
                begin
                    if (flag_hi)
                    begin
                        held_next  = pv[3:0];
                        drive_next = FLAG_DRIVE;
                        phase_next = PHASE_RX_LOW;
                    end
                end
                PHASE_RX_LOW:
                begin
                    if (flag_lo)
                    begin
                        drive_next        = '0;
                        res_next.rx_valid = 1'b1;
                        res_next.rx_byte  = {pv[3:0], held_reg};
                        phase_next        = PHASE_IDLE;
                    end
                end
                PHASE_TX_HIGH:
                begin
                    if (flag_hi || wait_out)
                    begin
                        if (!flag_hi)
                        begin
                            tmo_seen_next = 1'b1;
                        end
                        drive_next   = {4'h0, held_reg};
                        elapsed_next = '0;
                        phase_next   = PHASE_TX_LOW;
                    end
                    else
                    begin
                        elapsed_next = elapsed_reg + 1'b1;
                    end
                end
                PHASE_TX_LOW:
                begin
                    if (flag_lo || wait_out)
                    begin
                        res_next.tx_done      = 1'b1;
                        res_next.tx_timed_out = tmo_seen_reg || !flag_lo;
                        if (!flag_lo)
                        begin
                            tmo_seen_next = 1'b1;
                        end
                        phase_next = PHASE_IDLE;
                    end
                    else
                    begin
                        elapsed_next = elapsed_reg + 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PHASE_IDLE;
                end
            endcase
        end

        res_next.data_lines = drive_next;
        res_next.link_phase = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_axis_tready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= res_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_reg.link_phase, out_reg.request_refused,
                            out_reg.tx_timed_out, out_reg.tx_done, out_reg.rx_byte,
                            out_reg.rx_valid, out_reg.data_lines};

    // a finished receive or transmit always leaves the link idle
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_reg.rx_valid || out_reg.tx_done)
            |-> out_reg.link_phase == PHASE_IDLE)
        else $error("completion reported with link not idle");

    // a request taken while idle moves into the first transmit wait
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_op_reg == OP_TX_REQ && phase_reg == PHASE_IDLE
            |=> phase_reg == PHASE_TX_HIGH)
        else $error("transmit request did not start handshake");

    // a refused request leaves the phase alone
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && res_next.request_refused |=> phase_reg == $past(phase_reg))
        else $error("refused request changed phase");

    // receive and transmit never complete on the same item
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.rx_valid && out_reg.tx_done))
        else $error("receive and transmit completed together");

endmodule

[dv/tb.sv]
// Self-checking testbench for the nibble-mode parallel link core.
module tb;
    import nml_pkg::*;

    localparam int CYCLE_LIMIT = 100000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [TICK_W-1:0]    cfg_wr_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;  // status_lines[4:0], tx_byte[12:5]
    logic                 s_axis_tuser = 1'b0; // operation
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;       // data_lines, rx_valid, rx_byte, tx_done,
                                              // tx_timed_out, request_refused, link_phase

    nibble_mode_parallel_link_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 clk = ~clk;

    // link state as the testbench expects it
    logic [15:0] timeout_reg = TIMEOUT_RESET;
    logic [4:0]  stable_q = '0;
    logic        known_q = 1'b0;
    logic [4:0]  prev_q = '0;
    phase_t      phase_q = PHASE_IDLE;
    logic [3:0]  nib_q = '0;
    logic [15:0] elapsed_q = '0;
    logic        to_seen_q = 1'b0;
    logic [7:0]  drive_q = '0;

    result_t pending_results[$];
    result_t got_r, want_r;

    int  item_count = 0;
    int  rx_count = 0;
    int  tx_count = 0;
    int  tx_to_count = 0;
    int  refused_count = 0;
    int  fail_count = 0;
    int  cycles = 0;
    int  hold_req = 0;
    int  hold_left = 0;
    bit  idle_en = 1'b1;

    // one tick of a transmit wait; true once the wait has run out
    function automatic bit wait_expired();
        if (elapsed_q >= timeout_reg)
            return 1'b1;
        elapsed_q = elapsed_q + 16'd1;
        return 1'b0;
    endfunction

    function automatic result_t link_step(op_t op, logic [4:0] raw, logic [7:0] txb);
        result_t    r;
        logic [4:0] pv;
        logic       hi;
        logic       lo;
        r = '0;
        if (op == OP_TX_REQ)
        begin
            if (phase_q == PHASE_IDLE)
            begin
                drive_q   = FLAG_DRIVE | {4'h0, txb[3:0]};
                nib_q     = txb[7:4];
                elapsed_q = '0;
                to_seen_q = 1'b0;
                phase_q   = PHASE_TX_HIGH;
            end
            else
            begin
                r.request_refused = 1'b1;
            end
        end
        else
        begin
            if (raw == prev_q)
            begin
                stable_q = raw;
                known_q  = 1'b1;
            end
            prev_q = raw;
            pv = stable_q ^ BUSY_INVERT;
            hi = known_q && pv[4];
            lo = known_q && !pv[4];
            case (phase_q)
                PHASE_IDLE:
                begin
                    if (hi)
                    begin
                        nib_q   = pv[3:0];
                        drive_q = FLAG_DRIVE;
                        phase_q = PHASE_RX_LOW;
                    end
                end
                PHASE_RX_LOW:
                begin
                    if (lo)
                    begin
                        drive_q    = '0;
                        r.rx_valid = 1'b1;
                        r.rx_byte  = {pv[3:0], nib_q};
                        phase_q    = PHASE_IDLE;
                    end
                end
                PHASE_TX_HIGH:
                begin
                    if (hi || wait_expired())
                    begin
                        if (!hi)
                            to_seen_q = 1'b1;
                        drive_q   = {4'h0, nib_q};
                        elapsed_q = '0;
                        phase_q   = PHASE_TX_LOW;
                    end
                end
                default:
                begin
                    if (lo || wait_expired())
                    begin
                        if (!lo)
                            to_seen_q = 1'b1;
                        r.tx_done      = 1'b1;
                        r.tx_timed_out = to_seen_q;
                        phase_q        = PHASE_IDLE;
                    end
                end
            endcase
        end
        r.data_lines = drive_q;
        r.link_phase = phase_q;
        return r;
    endfunction

    function automatic result_t unpack_result(logic [M_TDATA_W-1:0] td);
        result_t r;
        r.data_lines      = td[7:0];
        r.rx_valid        = td[8];
        r.rx_byte         = td[16:9];
        r.tx_done         = td[17];
        r.tx_timed_out    = td[18];
        r.request_refused = td[19];
        r.link_phase      = phase_t'(td[21:20]);
        return r;
    endfunction

    // call at a rising edge; returns at the edge where the transfer happened
    task automatic send_item(op_t op, logic [4:0] raw, logic [7:0] txb);
        result_t r;
        if (idle_en && $urandom_range(0, 99) < 7)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {3'b000, txb, raw};
        do
            @(posedge clk);
        while (!s_axis_tready);
        r = link_step(op, raw, txb);
        pending_results.push_back(r);
        item_count++;
        rx_count      += r.rx_valid;
        tx_count      += r.tx_done;
        tx_to_count   += r.tx_timed_out;
        refused_count += r.request_refused;
    endtask

    task automatic send_sample(logic [4:0] raw);
        send_item(OP_SAMPLE, raw, 8'($urandom));
    endtask

    task automatic send_tx(logic [7:0] txb);
        send_item(OP_TX_REQ, 5'($urandom), txb);
    endtask

    // far end holds its flag; raw busy is the inverted flag
    task automatic host_level(bit flag, logic [3:0] nib, int reps);
        repeat (reps) send_sample({~flag, nib});
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_timeout(logic [15:0] ticks);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ticks;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        timeout_reg = ticks;
        @(posedge clk);
    endtask

    task automatic random_sequence();
        int pick;
        int variant;
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            host_level(1'b1, 4'($urandom), $urandom_range(2, 3));
            if ($urandom_range(0, 99) < 20)
                send_sample(5'($urandom));
            host_level(1'b0, 4'($urandom), $urandom_range(2, 3));
        end
        else if (pick < 75)
        begin
            send_tx(8'($urandom));
            variant = $urandom_range(0, 3);
            case (variant)
                1: host_level(1'b0, 4'($urandom), $urandom_range(1, 12)); // late ack
                2: host_level(1'b1, 4'($urandom), $urandom_range(2, 12)); // ack stuck high
                default: ;
            endcase
            host_level(1'b1, 4'($urandom), $urandom_range(2, 3));
            if (variant == 3)
                send_tx(8'($urandom));
            host_level(1'b0, 4'($urandom), $urandom_range(2, 3));
        end
        else
        begin
            repeat ($urandom_range(1, 6))
                send_item(($urandom_range(0, 99) < 20) ? OP_TX_REQ : OP_SAMPLE,
                           5'($urandom), 8'($urandom));
        end
    endtask

    task automatic test_directed();
        send_sample(5'h1F);          // nothing verified yet
        send_sample(5'h05);
        send_tx(8'hFF);              // waits only tick while the flag is unknown
        send_sample(5'h0A);
        send_sample(5'h15);
        send_tx(8'h00);              // busy -> refused
        send_sample(5'h00);
        send_sample(5'h00);          // flag high: high nibble goes out
        send_sample(5'h1F);
        send_sample(5'h1F);          // flag low: transmit done
        send_sample(5'h0F);
        send_sample(5'h0F);          // receive starts, low nibble F
        send_tx(8'h3C);              // refused during receive
        send_sample(5'h10);
        send_sample(5'h10);          // byte 0x0F
        send_sample(5'h00);
        send_sample(5'h00);
        send_sample(5'h1F);
        send_sample(5'h1F);          // byte 0xF0
    endtask

    task automatic test_timeout_extremes();
        wait_drained();
        set_timeout(16'd0);          // every wrong-flag sample runs out at once
        send_tx(8'h5A);
        host_level(1'b0, 4'hF, 3);
        send_tx(8'hA5);
        host_level(1'b1, 4'h0, 3);
        host_level(1'b0, 4'h3, 2);
        wait_drained();
        set_timeout(16'hFFFF);
        send_tx(8'hC3);
        host_level(1'b0, 4'h1, 6);
        host_level(1'b1, 4'h2, 2);
        host_level(1'b0, 4'h4, 2);
        wait_drained();
        set_timeout(16'd1);
        send_tx(8'h96);
        host_level(1'b1, 4'h8, 5);
        host_level(1'b0, 4'h7, 2);
        wait_drained();
        set_timeout(TIMEOUT_RESET);
    endtask

    task automatic test_backpressure();
        hold_req = 80;
        repeat (6) random_sequence();
    endtask

    task automatic test_drain_pause();
        send_tx(8'h81);
        host_level(1'b1, 4'h6, 2);
        host_level(1'b0, 4'h9, 2);
        wait_drained();
        host_level(1'b1, 4'hE, 2);
        host_level(1'b0, 4'h1, 2);
    endtask

    task automatic test_random();
        logic [15:0] settings[6];
        settings = '{TIMEOUT_RESET, 16'd3, 16'hFFFF, 16'($urandom_range(2, 40)), 16'd1, 16'd12};
        for (int i = 0; i < 6; i++)
        begin
            if (i != 0)
            begin
                wait_drained();
                set_timeout(settings[i]);
            end
            idle_en = (i != 2);      // one long stretch with no gaps at all
            while (item_count < 100 + (i + 1) * 140)
                random_sequence();
        end
        idle_en = 1'b1;
    endtask

    // receiver side: random stalls plus an occasional long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (hold_req != 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= !(idle_en && $urandom_range(0, 99) < 7);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_r = unpack_result(m_axis_tdata);
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected transfer on output: tdata=%h", m_axis_tdata);
            end
            else
            begin
                want_r = pending_results.pop_front();
                if (got_r !== want_r)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("mismatch exp: data=%h rxv=%b rxb=%h done=%b to=%b ref=%b ph=%0d",
                                 want_r.data_lines, want_r.rx_valid, want_r.rx_byte,
                                 want_r.tx_done, want_r.tx_timed_out, want_r.request_refused,
                                 want_r.link_phase);
                        $display("         got: data=%h rxv=%b rxb=%h done=%b to=%b ref=%b ph=%0d",
                                 got_r.data_lines, got_r.rx_valid, got_r.rx_byte,
                                 got_r.tx_done, got_r.tx_timed_out, got_r.request_refused,
                                 got_r.link_phase);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_timeout_extremes();
        test_backpressure();
        test_drain_pause();
        test_random();
        wait_drained();
        fail_count += pending_results.size();
        $display("%0d items: %0d bytes received, %0d transmits (%0d timed out), %0d refused",
                 item_count, rx_count, tx_count, tx_to_count, refused_count);
        $display("timeout register swept over 0, 1, 65535 and mid values; %0d failures",
                 fail_count);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
